FILE: design/lphm_pkg.sv
package lphm_pkg;

   localparam int TABLE_SLOTS = 128;
   localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
   localparam int OCC_BITS    = $clog2(TABLE_SLOTS + 1);
   localparam int KEY_BITS    = 64;
   localparam int VALUE_BITS  = 16;
   localparam int HASH_SHIFT  = 32;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_FIND   = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_UPDATE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_BAD_KEY   = 2'd3
   } status_type;

   typedef struct packed {
      mode_type              mode;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [VALUE_BITS-1:0] found_value;
      logic [SLOT_BITS-1:0]  slot;
   } rsp_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } entry_type;

   typedef struct packed {
      logic       load_req;
      logic       probe_home_req;
      logic       probe_home_moved;
      logic       probe_next;
      logic       rd_walk;
      logic       write_req;
      logic       occ_inc;
      logic       write_moved;
      logic       erase_probe;
      logic       take_walk;
      logic       walk_next;
      logic       res_set;
      status_type res_status;
      logic       res_slot;
      logic       res_value;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic     key_zero;
      mode_type mode;
      logic     table_full;
      logic     occ_probe;
      logic     occ_walk;
      logic     walk_last;
      logic     rd_occ;
      logic     rd_hit;
      logic     probe_last;
      logic     rsp_free;
   } stat_type;

   function automatic logic [SLOT_BITS-1:0] home_slot(input logic [KEY_BITS-1:0] key);
      return key[SLOT_BITS-1:0] ^ key[HASH_SHIFT +: SLOT_BITS];
   endfunction

endpackage

FILE: design/lphm_ctrl.sv
module lphm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lphm_pkg::stat_type stat,
   output lphm_pkg::cmd_type  cmd
);
   import lphm_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_START    = 9'b000000010,
      ST_INS_SCAN = 9'b000000100,
      ST_LK_RD    = 9'b000001000,
      ST_LK_CMP   = 9'b000010000,
      ST_RM_SCAN  = 9'b000100000,
      ST_RM_RD    = 9'b001000000,
      ST_RM_PLACE = 9'b010000000,
      ST_DONE     = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_START;
            end
         end
         ST_START: begin
            if (stat.key_zero) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = STATUS_BAD_KEY;
               state_in       = ST_DONE;
            end else if (stat.mode == MODE_INSERT) begin
               if (stat.table_full) begin
                  cmd.res_set    = 1'b1;
                  cmd.res_status = STATUS_FULL;
                  state_in       = ST_DONE;
               end else begin
                  cmd.probe_home_req = 1'b1;
                  state_in           = ST_INS_SCAN;
               end
            end else begin
               cmd.probe_home_req = 1'b1;
               state_in           = ST_LK_RD;
            end
         end
         ST_INS_SCAN: begin
            if (!stat.occ_probe) begin
               cmd.write_req  = 1'b1;
               cmd.occ_inc    = 1'b1;
               cmd.res_set    = 1'b1;
               cmd.res_status = STATUS_OK;
               cmd.res_slot   = 1'b1;
               state_in       = ST_DONE;
            end else begin
               cmd.probe_next = 1'b1;
            end
         end
         ST_LK_RD: begin
            state_in = ST_LK_CMP;
         end
         ST_LK_CMP: begin
            if (stat.rd_hit) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = STATUS_OK;
               cmd.res_slot   = 1'b1;
               case (stat.mode)
                  MODE_FIND: begin
                     cmd.res_value = 1'b1;
                     state_in      = ST_DONE;
                  end
                  MODE_REMOVE: begin
                     cmd.erase_probe = 1'b1;
                     state_in        = ST_RM_SCAN;
                  end
                  default: begin
                     cmd.write_req = 1'b1;
                     state_in      = ST_DONE;
                  end
               endcase
            end else if (!stat.rd_occ || stat.probe_last) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = STATUS_NOT_FOUND;
               state_in       = ST_DONE;
            end else begin
               cmd.probe_next = 1'b1;
               state_in       = ST_LK_RD;
            end
         end
         ST_RM_SCAN: begin
            cmd.rd_walk = 1'b1;
            if (stat.occ_walk) begin
               state_in = ST_RM_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RM_RD: begin
            cmd.take_walk        = 1'b1;
            cmd.probe_home_moved = 1'b1;
            state_in             = ST_RM_PLACE;
         end
         ST_RM_PLACE: begin
            if (!stat.occ_probe) begin
               cmd.write_moved = 1'b1;
               cmd.walk_next   = 1'b1;
               if (stat.walk_last) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_RM_SCAN;
               end
            end else begin
               cmd.probe_next = 1'b1;
            end
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/lphm_datapath.sv
module lphm_datapath (
   input  logic              clock,
   input  logic              reset,
   input  lphm_pkg::req_type  req_data,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output lphm_pkg::rsp_type  rsp_data,
   input  lphm_pkg::cmd_type  cmd,
   output lphm_pkg::stat_type stat
);
   import lphm_pkg::*;

   entry_type mem [TABLE_SLOTS];

   req_type                req_ff;
   logic [SLOT_BITS-1:0]   probe_ff, probe_in;
   logic [SLOT_BITS-1:0]   walk_ff, walk_in;
   logic [SLOT_BITS-1:0]   walk_cnt_ff, walk_cnt_in;
   logic [SLOT_BITS-1:0]   count_ff, count_in;
   logic [TABLE_SLOTS-1:0] occ_ff, occ_in;
   logic [OCC_BITS-1:0]    occupancy_ff, occupancy_in;
   entry_type              rd_data_ff;
   logic                   rd_occ_ff;
   entry_type              moved_ff;
   rsp_type                res_ff, res_in;
   rsp_type                rsp_ff;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [SLOT_BITS-1:0]   rd_addr;
   logic                   wr_en;
   entry_type              wr_data;

   assign rd_addr = cmd.rd_walk ? walk_ff : probe_ff;
   assign wr_en   = cmd.write_req || cmd.write_moved;
   assign wr_data = cmd.write_moved ? moved_ff : entry_type'{req_ff.key, req_ff.value};

   always_comb begin
      probe_in = probe_ff;
      count_in = count_ff;
      if (cmd.probe_home_req) begin
         probe_in = home_slot(req_ff.key);
         count_in = '0;
      end else if (cmd.probe_home_moved) begin
         probe_in = home_slot(rd_data_ff.key);
         count_in = '0;
      end else if (cmd.probe_next) begin
         probe_in = probe_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end
   end

   always_comb begin
      walk_in     = walk_ff;
      walk_cnt_in = walk_cnt_ff;
      if (cmd.erase_probe) begin
         walk_in     = probe_ff + 1'b1;
         walk_cnt_in = '0;
      end else if (cmd.walk_next) begin
         walk_in     = walk_ff + 1'b1;
         walk_cnt_in = walk_cnt_ff + 1'b1;
      end
   end

   always_comb begin
      occ_in       = occ_ff;
      occupancy_in = occupancy_ff;
      if (cmd.erase_probe) begin
         occ_in[probe_ff] = 1'b0;
         occupancy_in     = occupancy_ff - 1'b1;
      end
      if (cmd.take_walk) begin
         occ_in[walk_ff] = 1'b0;
      end
      if (wr_en) begin
         occ_in[probe_ff] = 1'b1;
      end
      if (cmd.occ_inc) begin
         occupancy_in = occupancy_ff + 1'b1;
      end
   end

   always_comb begin
      res_in = res_ff;
      if (cmd.res_set) begin
         res_in.status      = cmd.res_status;
         res_in.slot        = cmd.res_slot ? probe_ff : '0;
         res_in.found_value = cmd.res_value ? rd_data_ff.value : '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[probe_ff] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.take_walk) begin
         moved_ff <= rd_data_ff;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= res_ff;
      end
      probe_ff    <= probe_in;
      walk_ff     <= walk_in;
      walk_cnt_ff <= walk_cnt_in;
      count_ff    <= count_in;
      res_ff      <= res_in;
      rd_occ_ff   <= occ_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         occupancy_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         occupancy_ff <= occupancy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      stat            = '0;
      stat.key_zero   = (req_ff.key == '0);
      stat.mode       = req_ff.mode;
      stat.table_full = (occupancy_ff == OCC_BITS'(TABLE_SLOTS));
      stat.occ_probe  = occ_ff[probe_ff];
      stat.occ_walk   = occ_ff[walk_ff];
      stat.walk_last  = (walk_cnt_ff == SLOT_BITS'(TABLE_SLOTS - 1));
      stat.rd_occ     = rd_occ_ff;
      stat.rd_hit     = rd_occ_ff && (rd_data_ff.key == req_ff.key);
      stat.probe_last = (count_ff == SLOT_BITS'(TABLE_SLOTS - 1));
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

`ifndef SYNTHESIS
   occupancy_bound_a: assert property (@(posedge clock) disable iff (reset)
      occupancy_ff <= OCC_BITS'(TABLE_SLOTS))
      else $error("Occupancy count exceeds the table size.");

   occupancy_match_a: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |-> occupancy_ff == OCC_BITS'($countones(occ_ff)))
      else $error("Occupancy count disagrees with the occupied slots at item start.");

   place_empty_a: assert property (@(posedge clock) disable iff (reset)
      ((cmd.write_req && cmd.occ_inc) || cmd.write_moved) |-> !occ_ff[probe_ff])
      else $error("An entry is placed into an occupied slot.");

   erase_occupied_a: assert property (@(posedge clock) disable iff (reset)
      cmd.erase_probe |-> occ_ff[probe_ff])
      else $error("A remove empties a slot that is not occupied.");
`endif

endmodule

FILE: design/linear_probe_hash_map.sv
// Channel   Handshake                 Payload
// req       req_valid / req_ready     req_data  (mode, key, value)
// rsp       rsp_valid / rsp_ready     rsp_data  (status, found_value, slot)
//
// One item is worked on at a time; the slot-occupied bits are flip-flops, the
// entries sit in a single-port table memory with a registered read.
// Insert probes from the home slot past each occupied slot and writes the
// first free one; find, update and remove read and compare each slot probed,
// and remove then reads each following cluster entry and places it again from
// its home slot on, passing occupied slots, until the cluster ends.
// Reset clears all occupied bits at once, so no clearing pass is needed.
// A new item is taken while the previous result waits in the output register.
module linear_probe_hash_map (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lphm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lphm_pkg::rsp_type rsp_data
);
   import lphm_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   lphm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lphm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule
